### src/tape_pulse_player_top_defines.svh
// assertion macros for the tape pulse player
`ifndef TAPE_PULSE_PLAYER_TOP_DEFINES_SVH
`define TAPE_PULSE_PLAYER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tpp_pkg.sv
// shared types and constants of the tape pulse player
package tpp_pkg;

  localparam int unsigned DEF_TAPE_BYTES = 1048576;
  localparam int unsigned DEF_MAX_TICKS  = 15;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 20;
  localparam int BYTE_W     = 8;
  localparam int TICK_W     = 4;
  localparam int PULSE_W    = 4;
  localparam int POS_W      = 21;
  localparam int CNT_W      = 24;
  localparam int LIM_W      = 25;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam int UNIT_SHIFT = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_REWIND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'd1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_ADVANCE,
    CMD_REWIND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wbyte;
    logic [TICK_W-1:0] ticks;
    logic              irq_en;
  } cmd_t;

  typedef struct packed {
    logic              version;
    logic [POS_W-1:0]  length;
  } cfg_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

### src/tpp_if.sv
// input and result channel interfaces of the tape pulse player
interface tpp_in_if;
  import tpp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] write_address;
  logic [BYTE_W-1:0] write_byte;
  logic [TICK_W-1:0] tick_count;
  logic              motor_off;
  logic              flag_irq_enabled;

  modport source (
    output valid, operation, write_address, write_byte, tick_count, motor_off,
           flag_irq_enabled,
    input  ready
  );
  modport sink (
    input  valid, operation, write_address, write_byte, tick_count, motor_off,
           flag_irq_enabled,
    output ready
  );
endinterface

interface tpp_out_if;
  import tpp_pkg::*;
  logic               valid;
  logic               ready;
  logic               tape_end;
  logic [PULSE_W-1:0] pulse_count;
  logic               irq_request;

  modport source (
    output valid, tape_end, pulse_count, irq_request,
    input  ready
  );
  modport sink (
    input  valid, tape_end, pulse_count, irq_request,
    output ready
  );
endinterface

### src/tpp_queue.sv
// two-entry command queue between the front and the engine
module tpp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tpp_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output tpp_pkg::cmd_t   head_cmd,
  output tpp_pkg::q_stat_t stat
);
  import tpp_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = cnt_r;
endmodule

### src/tpp_front.sv
// front end: takes input beats and classifies them into engine commands
module tpp_front #(
  parameter int unsigned TAPE_BYTES = tpp_pkg::DEF_TAPE_BYTES,
  parameter int unsigned MAX_TICKS  = tpp_pkg::DEF_MAX_TICKS
) (
  tpp_in_if.sink         in_if,
  input  logic           q_full,
  output logic           push,
  output tpp_pkg::cmd_t  cmd
);
  import tpp_pkg::*;

  localparam logic [LIM_W-1:0] TAPE_LIM = LIM_W'(TAPE_BYTES);

  logic [TICK_W-1:0] ticks_c;
  logic              addr_ok;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  assign ticks_c = (int'(in_if.tick_count) > int'(MAX_TICKS)) ? TICK_W'(MAX_TICKS)
                                                              : in_if.tick_count;
  assign addr_ok = (LIM_W'(in_if.write_address) < TAPE_LIM);

  always_comb begin
    cmd.addr   = in_if.write_address;
    cmd.wbyte  = in_if.write_byte;
    cmd.ticks  = ticks_c;
    cmd.irq_en = in_if.flag_irq_enabled;
    unique case (in_if.operation)
      OP_WRITE:   cmd.kind = addr_ok ? CMD_WRITE : CMD_NOP;
      OP_ADVANCE: cmd.kind = (!in_if.motor_off && ticks_c != '0) ? CMD_ADVANCE : CMD_NOP;
      OP_REWIND:  cmd.kind = CMD_REWIND;
      default:    cmd.kind = CMD_NOP;
    endcase
  end
endmodule

### src/tpp_engine.sv
// back end: tape memory, countdown sequencer and result register
module tpp_engine #(
  parameter int unsigned TAPE_BYTES = tpp_pkg::DEF_TAPE_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tpp_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  tpp_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  tpp_out_if.source      out_if
);
  import tpp_pkg::*;

  localparam int               AW       = $clog2(TAPE_BYTES);
  localparam logic [LIM_W-1:0] TAPE_LIM = LIM_W'(TAPE_BYTES);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RUN  = 7'b0000010,
    ST_BYTE = 7'b0000100,
    ST_L0   = 7'b0001000,
    ST_L1   = 7'b0010000,
    ST_L2   = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   cd_r, cd_nxt;
  logic [TICK_W-1:0]  rem_r, rem_nxt;
  logic [PULSE_W-1:0] pulses_r, pulses_nxt;
  logic               irq_r, irq_nxt;
  logic               irq_en_r, irq_en_nxt;
  logic               ended_r, ended_nxt;
  logic [CNT_W-1:0]   lc_r, lc_nxt;

  logic [BYTE_W-1:0]  mem [TAPE_BYTES];
  logic [BYTE_W-1:0]  rd_data_r;
  logic               rd_ok_r;

  logic               out_valid_r;
  logic               tape_end_r;
  logic [PULSE_W-1:0] pulse_out_r;
  logic               irq_out_r;

  logic [POS_W:0]     rd_pos;
  logic               rd_ok;
  logic [AW-1:0]      rd_addr;
  logic [BYTE_W-1:0]  byte_v;
  logic [CNT_W-1:0]   k;
  logic               expire;
  logic [POS_W-1:0]   pos_inc1;
  logic [POS_W:0]     pos_sum3;
  logic [POS_W-1:0]   pos_inc3;
  logic               ended_now;
  logic               out_free;
  logic               mem_we;

  // read position of the fetch issued in this state
  always_comb begin
    case (state_r)
      ST_L0:   rd_pos = {1'b0, pos_r} + (POS_W + 1)'(1);
      ST_L1:   rd_pos = {1'b0, pos_r} + (POS_W + 1)'(2);
      default: rd_pos = {1'b0, pos_r};
    endcase
  end

  assign rd_ok   = (rd_pos < {1'b0, cfg.length}) && (LIM_W'(rd_pos) < TAPE_LIM);
  assign rd_addr = AW'(rd_pos);
  assign byte_v  = rd_ok_r ? rd_data_r : '0;

  assign k         = (cd_r == '0) ? CNT_W'(1) : cd_r;
  assign expire    = (CNT_W'(rem_r) >= k);
  assign pos_inc1  = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
  assign pos_sum3  = {1'b0, pos_r} + (POS_W + 1)'(3);
  assign pos_inc3  = (pos_sum3 > {1'b0, POS_MAX}) ? POS_MAX : pos_sum3[POS_W-1:0];
  assign ended_now = (pos_r >= cfg.length);
  assign out_free  = !out_valid_r || out_if.ready;

  assign q_pop  = (state_r == ST_IDLE) && q_valid;
  assign mem_we = q_pop && (q_cmd.kind == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_cmd.addr)] <= q_cmd.wbyte;
    end
    rd_data_r <= mem[rd_addr];
    rd_ok_r   <= rd_ok;
  end

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    cd_nxt     = cd_r;
    rem_nxt    = rem_r;
    pulses_nxt = pulses_r;
    irq_nxt    = irq_r;
    irq_en_nxt = irq_en_r;
    ended_nxt  = ended_r;
    lc_nxt     = lc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          ended_nxt  = ended_now;
          pulses_nxt = '0;
          irq_nxt    = 1'b0;
          irq_en_nxt = q_cmd.irq_en;
          rem_nxt    = q_cmd.ticks;
          state_nxt  = ST_DONE;
          case (q_cmd.kind)
            CMD_REWIND: begin
              pos_nxt = '0;
              cd_nxt  = CNT_W'(1);
            end
            CMD_ADVANCE: begin
              if (!ended_now) begin
                state_nxt = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (expire) begin
          rem_nxt    = rem_r - TICK_W'(k);
          pulses_nxt = (pulses_r == '1) ? pulses_r : pulses_r + 1'b1;
          irq_nxt    = irq_r | irq_en_r;
          pos_nxt    = pos_inc1;
          state_nxt  = ST_BYTE;
        end else begin
          cd_nxt    = cd_r - CNT_W'(rem_r);
          state_nxt = ST_DONE;
        end
      end
      ST_BYTE: begin
        if (byte_v == '0 && cfg.version) begin
          state_nxt = ST_L0;
        end else begin
          cd_nxt    = CNT_W'({byte_v, UNIT_SHIFT'(0)});
          state_nxt = ST_RUN;
        end
      end
      ST_L0: begin
        lc_nxt    = {byte_v, lc_r[CNT_W-1:BYTE_W]};
        state_nxt = ST_L1;
      end
      ST_L1: begin
        lc_nxt    = {byte_v, lc_r[CNT_W-1:BYTE_W]};
        state_nxt = ST_L2;
      end
      ST_L2: begin
        cd_nxt    = {byte_v, lc_r[CNT_W-1:BYTE_W]};
        pos_nxt   = pos_inc3;
        state_nxt = ST_RUN;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cd_r        <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cd_r    <= cd_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    pulses_r <= pulses_nxt;
    irq_r    <= irq_nxt;
    irq_en_r <= irq_en_nxt;
    ended_r  <= ended_nxt;
    lc_r     <= lc_nxt;
    if (state_r == ST_DONE && out_free) begin
      tape_end_r  <= ended_r;
      pulse_out_r <= pulses_r;
      irq_out_r   <= irq_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.tape_end    = tape_end_r;
  assign out_if.pulse_count = pulse_out_r;
  assign out_if.irq_request = irq_out_r;
endmodule

### src/tape_pulse_player_top.sv
// top level of the tape pulse player
// Plays back a cassette pulse image held in an internal byte memory of TAPE_BYTES
// entries. Input beats are classified and queued (two entries), so the input side
// keeps taking beats while the engine works and a result waits. Every beat gives
// one result. Write, rewind and idle beats go straight to the done state, as does
// an advance on an ended tape, with the motor off or with no ticks. An advance
// that runs passes the run state and a byte state per pulse, plus L0, L1 and L2
// per long count in version 1, as the single read port of the tape memory fetches
// one byte per clock. A result not taken holds the engine in its done state. The
// tape memory is not cleared at reset; bytes at or past the configured length
// read as zero. The user must write configuration through cfg_we, cfg_index and
// cfg_wdata while the block is idle; the block itself does not enforce this.
`include "tape_pulse_player_top_defines.svh"

module tape_pulse_player_top #(
  parameter int unsigned TAPE_BYTES = tpp_pkg::DEF_TAPE_BYTES,
  parameter int unsigned MAX_TICKS  = tpp_pkg::DEF_MAX_TICKS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  tpp_in_if.sink                           in_chan,
  tpp_out_if.source                        out_chan
);
  import tpp_pkg::*;

  cfg_t    cfg_r;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERSION: cfg_r.version <= cfg_wdata[0];
        REG_LENGTH:  cfg_r.length  <= cfg_wdata;
      endcase
    end
  end

  tpp_front #(
    .TAPE_BYTES (TAPE_BYTES),
    .MAX_TICKS  (MAX_TICKS)
  ) u_front (
    .in_if  (in_chan),
    .q_full (q_stat.full),
    .push   (q_push),
    .cmd    (push_cmd)
  );

  tpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tpp_engine #(
    .TAPE_BYTES (TAPE_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (!q_stat.empty),
    .q_cmd   (head_cmd),
    .q_pop   (q_pop),
    .out_if  (out_chan)
  );

  `TPP_ASSERT_NOW(a_irq_needs_pulse, out_chan.valid && out_chan.irq_request,
                  out_chan.pulse_count != '0, "irq reported without a pulse")
  `TPP_ASSERT_NOW(a_ended_no_pulse, out_chan.valid && out_chan.tape_end,
                  out_chan.pulse_count == '0 && !out_chan.irq_request,
                  "pulses reported on ended tape")
  `TPP_ASSERT_NEXT(a_queue_fill, q_push && !q_pop,
                   q_stat.count == $past(q_stat.count) + 1'b1,
                   "queue count did not grow on push")
endmodule

### verif/tb_top.sv
// testbench for the tape pulse player: directed and random playback checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import tpp_pkg::*;

  localparam int unsigned TAPE_BYTES  = DEF_TAPE_BYTES;
  localparam int unsigned MAX_TICKS   = DEF_MAX_TICKS;
  localparam int unsigned PRIME_SPAN  = 64;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [TICK_W-1:0] ticks;
    logic              motor_off;
    logic              irq_en;
  } tape_beat_t;

  typedef struct {
    logic               tape_end;
    logic [PULSE_W-1:0] pulses;
    logic               irq;
  } play_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tpp_in_if  in_if ();
  tpp_out_if out_if ();

  tape_pulse_player_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // playback state as the block should hold it
  bit [BYTE_W-1:0] tape_image [int unsigned];
  int unsigned     play_pos       = 0;
  int              play_countdown = 1;
  logic            play_version   = 1'b0;
  int unsigned     play_length    = 0;

  play_result_t pending_results[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           beats_sent     = 0;
  int           send_idle_pct  = 26;
  int           recv_stall_pct = 55;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    play_result_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (end %b pulses %0d irq %b)",
                                  out_if.tape_end, out_if.pulse_count, out_if.irq_request));
      end else begin
        want = pending_results.pop_front();
        if (out_if.tape_end !== want.tape_end)
          report_mismatch($sformatf("tape_end got %b expected %b",
                                    out_if.tape_end, want.tape_end));
        if (out_if.pulse_count !== want.pulses)
          report_mismatch($sformatf("pulse_count got %0d expected %0d",
                                    out_if.pulse_count, want.pulses));
        if (out_if.irq_request !== want.irq)
          report_mismatch($sformatf("irq_request got %b expected %b",
                                    out_if.irq_request, want.irq));
      end
    end
  end

  function automatic int unsigned tape_fetch(input int unsigned pos);
    if (pos >= play_length || pos >= TAPE_BYTES) return 0;
    if (tape_image.exists(pos)) return 32'(tape_image[pos]);
    return 0;
  endfunction

  function automatic void bump_pos();
    if (play_pos < POS_MAX) play_pos++;
  endfunction

  function automatic play_result_t predict_playback(input tape_beat_t b);
    play_result_t r;
    int unsigned  load;
    int unsigned  n;
    r.tape_end = (play_pos >= play_length);
    r.pulses   = '0;
    r.irq      = 1'b0;
    case (b.op)
      OP_WRITE: begin
        if (b.addr < TAPE_BYTES) tape_image[b.addr] = b.data;
      end
      OP_REWIND: begin
        play_pos       = 0;
        play_countdown = 1;
      end
      OP_ADVANCE: begin
        if (!r.tape_end && !b.motor_off) begin
          n = (b.ticks > MAX_TICKS) ? MAX_TICKS : 32'(b.ticks);
          for (int i = 0; i < n; i++) begin
            play_countdown--;
            if (play_countdown <= 0) begin
              load = tape_fetch(play_pos) * 8;
              bump_pos();
              if (load == 0 && play_version) begin
                load = tape_fetch(play_pos) | (tape_fetch(play_pos + 1) << 8)
                       | (tape_fetch(play_pos + 2) << 16);
                bump_pos();
                bump_pos();
                bump_pos();
              end
              play_countdown = int'(load);
              if (r.pulses != '1) r.pulses++;
              if (b.irq_en) r.irq = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tape_beat_t make_beat(input logic [OP_W-1:0] op);
    tape_beat_t b;
    b.op        = op;
    b.addr      = ADDR_W'($urandom);
    b.data      = BYTE_W'($urandom);
    b.ticks     = TICK_W'($urandom);
    b.motor_off = 1'($urandom);
    b.irq_en    = 1'($urandom);
    return b;
  endfunction

  // mostly short pulses, some zero bytes, some full range
  function automatic logic [BYTE_W-1:0] pulse_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 70) return BYTE_W'($urandom_range(1, 3));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] long_count();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 85) return 24'($urandom_range(1, 40));
    return 24'($urandom_range(0, 4095));
  endfunction

  task automatic send_beat(input tape_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.operation        <= b.op;
    in_if.write_address    <= b.addr;
    in_if.write_byte       <= b.data;
    in_if.tick_count       <= b.ticks;
    in_if.motor_off        <= b.motor_off;
    in_if.flag_irq_enabled <= b.irq_en;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_playback(b));
    beats_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_VERSION) play_version = data[0];
    else if (idx == REG_LENGTH) play_length = 32'(data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_tape(input logic ver, input int unsigned len);
    write_reg(REG_VERSION, CFG_DATA_W'(ver));
    write_reg(REG_LENGTH, len[CFG_DATA_W-1:0]);
  endtask

  task automatic put_byte(input int unsigned addr, input logic [BYTE_W-1:0] data);
    tape_beat_t b;
    b      = make_beat(OP_WRITE);
    b.addr = addr[ADDR_W-1:0];
    b.data = data;
    send_beat(b);
  endtask

  task automatic rewind_tape();
    send_beat(make_beat(OP_REWIND));
  endtask

  // fill every unwritten byte that the next advance could fetch
  task automatic prime_ahead();
    logic [BYTE_W-1:0] pb;
    logic [23:0]       cnt;
    for (int unsigned p = play_pos; p < play_pos + PRIME_SPAN; p++) begin
      if (p < play_length && p < TAPE_BYTES && !tape_image.exists(p)) begin
        pb = pulse_byte();
        put_byte(p, pb);
        if (play_version && pb == 0) begin
          cnt = long_count();
          for (int k = 1; k <= 3; k++)
            if (p + k < TAPE_BYTES) put_byte(p + k, 8'(cnt >> (8 * (k - 1))));
        end
      end
    end
  endtask

  task automatic play(input int ticks, input logic motor_off, input logic irq_en);
    tape_beat_t b;
    prime_ahead();
    b           = make_beat(OP_ADVANCE);
    b.ticks     = TICK_W'(ticks);
    b.motor_off = motor_off;
    b.irq_en    = irq_en;
    send_beat(b);
  endtask

  task automatic test_idle_operations();
    play(15, 1'b0, 1'b1);
    send_beat(make_beat(OP_SPARE));
    rewind_tape();
    put_byte(0, 8'h00);
    put_byte(20'hFFFFF, 8'hFF);
  endtask

  // short counts, zero countdown, motor off, read past length up to the largest pulse count
  task automatic test_short_counts();
    put_byte(0, 8'd1);
    put_byte(1, 8'd0);
    put_byte(2, 8'd2);
    put_byte(3, 8'd0);
    set_tape(1'b0, 4);
    rewind_tape();
    play(1, 1'b0, 1'b1);
    play(15, 1'b1, 1'b1);
    play(0, 1'b0, 1'b1);
    play(8, 1'b0, 1'b0);
    play(1, 1'b0, 1'b1);
    play(15, 1'b0, 1'b1);
    play(15, 1'b0, 1'b1);
    play(15, 1'b0, 1'b1);
  endtask

  // version 1 long counts, including a zero long count and one past length
  task automatic test_long_counts();
    logic [BYTE_W-1:0] image [9];
    image = '{8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2};
    for (int i = 0; i < 9; i++) put_byte(i, image[i]);
    set_tape(1'b1, 9);
    rewind_tape();
    play(1, 1'b0, 1'b1);
    play(3, 1'b0, 1'b1);
    play(2, 1'b0, 1'b0);
    play(15, 1'b0, 1'b1);
  endtask

  task automatic run_setting(input int quota);
    tape_beat_t b;
    int         start;
    int         r;
    bit         paused;
    start  = beats_sent;
    paused = 0;
    while (beats_sent - start < quota) begin
      if (beats_sent - start >= quota / 2 && !paused) begin
        drain_results();
        paused = 1;
      end
      r = $urandom_range(99);
      if (r < 6 || (play_pos >= play_length && r < 50)) begin
        rewind_tape();
      end else if (r < 9) begin
        send_beat(make_beat(OP_SPARE));
      end else if (r < 35) begin
        b = make_beat(OP_WRITE);
        if ($urandom_range(99) < 75) b.addr = ADDR_W'(play_pos + $urandom_range(0, 80));
        if ($urandom_range(99) < 60) b.data = pulse_byte();
        send_beat(b);
      end else begin
        play($urandom_range(0, 15), $urandom_range(99) < 10, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic        versions [9];
    int unsigned lengths  [9];
    versions = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    lengths  = '{200, 1048576, 0, 150, 2097151, 1, 300, 64, 1048576};
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_stall_pct = 55; end
        1: begin send_idle_pct = 55; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        set_tape(versions[phase * 3 + s], lengths[phase * 3 + s]);
        run_setting(57);
      end
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.operation        = OP_WRITE;
    in_if.write_address    = '0;
    in_if.write_byte       = '0;
    in_if.tick_count       = '0;
    in_if.motor_off        = 1'b0;
    in_if.flag_irq_enabled = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_operations();
    test_short_counts();
    test_long_counts();
    test_random_traffic();
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
